FILE: rtl/dwat_pkg.sv
// Shared types and constants of the device-to-worker affinity table.
package dwat_pkg;

   localparam int USER_DEPTH = 16;
   localparam int AUTO_DEPTH = 64;
   localparam int KEY_BITS   = 32;

   // Only the low KEY_BITS of the 32-bit device key take part in compares.
   localparam int KEY_W     = (KEY_BITS < 32) ? KEY_BITS : 32;
   localparam int GROUP_W   = 8;
   localparam int POOL_W    = 8;
   localparam int COUNT_W   = 7;
   localparam int MOD_IDX_W = $clog2(COUNT_W);
   localparam int UIDX_W    = (USER_DEPTH > 1) ? $clog2(USER_DEPTH) : 1;
   localparam int AIDX_W    = (AUTO_DEPTH > 1) ? $clog2(AUTO_DEPTH) : 1;
   localparam int SCAN_W    = (UIDX_W > AIDX_W) ? UIDX_W : AIDX_W;
   localparam int ENTRY_W   = KEY_W + GROUP_W;

   // The last code carries no meaning and is answered as a pass-through.
   typedef enum logic [1:0] {
      OP_ASSIGN = 2'd0,
      OP_PIN    = 2'd1,
      OP_QUERY  = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      RS_USER_HIT   = 3'd0,
      RS_AUTO_HIT   = 3'd1,
      RS_NEW        = 3'd2,
      RS_PASS       = 3'd3,
      RS_NOT_MAPPED = 3'd4,
      RS_AUTO_FULL  = 3'd5,
      RS_PINNED     = 3'd6,
      RS_USER_FULL  = 3'd7
   } rsp_status_type;

   typedef enum logic [1:0] {
      GRP_ZERO = 2'd0,
      GRP_PIN  = 2'd1,
      GRP_HIT  = 2'd2,
      GRP_NEW  = 2'd3
   } grp_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_CHECK = 3'd1,
      ST_USCAN = 3'd2,
      ST_ASCAN = 3'd3,
      ST_MOD   = 3'd4
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           load;
      logic           scan_clear;
      logic           scan_en;
      logic           table_auto;
      logic           mod_start;
      logic           finish;
      rsp_status_type status;
      grp_sel_type    grp_sel;
      logic           user_write;
      logic           auto_write;
      logic           count_update;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] op;
      logic       has_device;
      logic       pool_zero;
      logic       scan_done;
      logic       hit;
      logic       free_found;
      logic       mod_busy;
      logic       rsp_busy;
   } stat_type;

endpackage

FILE: rtl/device_to_worker_affinity_table_core.sv
// Top level of the device-to-worker affinity table: controller and datapath.
//
// Usage. A request word on the req_ channel carries an operation (assign, pin or
// query), a has-device flag, a device key and a group number to pin. It is taken
// at a rising clock edge with req_valid high and req_stall low. Every request
// gives exactly one response word on the rsp_ channel: a status code and a group
// number. The pool size register is written through the csr_ channel, which is
// always ready; write it only while the block is idle.
// Sequencing. The block works on one request at a time and stalls the request side
// meanwhile. A pass-through is answered from the check state once the output
// register is free, and the block then returns to idle for the next request.
// Otherwise the user table is scanned one entry per cycle through its memory read
// port, then, on a miss of an assign or a query, the auto table, and a new device
// then goes through the bit-serial remainder unit. The table scans set the worst
// case from one accepted request to the next.
// Stalls. The response sits in an output register; the next request is taken
// while it waits. A finished result waits for the slot to drain when rsp_stall
// stays high. Reset empties both tables, clears the new-device counter and the
// pool size, and needs no clearing pass.
module device_to_worker_affinity_table_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [dwat_pkg::POOL_W-1:0]  csr_pool_size,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_operation,
   input  logic                         req_has_device,
   input  logic [31:0]                  req_device_key,
   input  logic [dwat_pkg::GROUP_W-1:0] req_pin_thread,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic [dwat_pkg::GROUP_W-1:0] rsp_group_number
);
   import dwat_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The configuration register takes a write in any cycle.
   assign csr_ready = 1'b1;

   dwat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dwat_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_pool_size    (csr_pool_size),
      .req_operation    (req_operation),
      .req_has_device   (req_has_device),
      .req_device_key   (req_device_key),
      .req_pin_thread   (req_pin_thread),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_group_number (rsp_group_number),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

FILE: rtl/dwat_ctrl.sv
// Controller state machine of the affinity table: sequences load, scans, modulo and result.
module dwat_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dwat_pkg::stat_type stat,
   output dwat_pkg::cmd_type  cmd
);
   import dwat_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.status  = RS_PASS;
      cmd.grp_sel = GRP_ZERO;
      req_stall = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (!stat.has_device || (stat.op == OP_UNUSED) ||
                ((stat.op == OP_ASSIGN) && stat.pool_zero)) begin
               if (!stat.rsp_busy) begin
                  cmd.finish  = 1'b1;
                  cmd.status  = RS_PASS;
                  cmd.grp_sel = GRP_ZERO;
                  state_in    = ST_IDLE;
               end
            end else begin
               state_in = ST_USCAN;
            end
         end

         ST_USCAN: begin
            cmd.scan_en = 1'b1;
            if (stat.scan_done) begin
               if (stat.op == OP_PIN) begin
                  if (!stat.rsp_busy) begin
                     cmd.finish = 1'b1;
                     state_in   = ST_IDLE;
                     if (stat.hit || stat.free_found) begin
                        cmd.status     = RS_PINNED;
                        cmd.grp_sel    = GRP_PIN;
                        cmd.user_write = 1'b1;
                     end else begin
                        cmd.status = RS_USER_FULL;
                     end
                  end
               end else if (stat.hit) begin
                  if (!stat.rsp_busy) begin
                     cmd.finish  = 1'b1;
                     cmd.status  = RS_USER_HIT;
                     cmd.grp_sel = GRP_HIT;
                     state_in    = ST_IDLE;
                  end
               end else begin
                  cmd.scan_clear = 1'b1;
                  state_in       = ST_ASCAN;
               end
            end
         end

         ST_ASCAN: begin
            cmd.scan_en    = 1'b1;
            cmd.table_auto = 1'b1;
            if (stat.scan_done) begin
               if (stat.hit) begin
                  if (!stat.rsp_busy) begin
                     cmd.finish  = 1'b1;
                     cmd.status  = RS_AUTO_HIT;
                     cmd.grp_sel = GRP_HIT;
                     state_in    = ST_IDLE;
                  end
               end else if (stat.op == OP_QUERY) begin
                  if (!stat.rsp_busy) begin
                     cmd.finish = 1'b1;
                     cmd.status = RS_NOT_MAPPED;
                     state_in   = ST_IDLE;
                  end
               end else if (stat.free_found) begin
                  cmd.mod_start = 1'b1;
                  state_in      = ST_MOD;
               end else begin
                  if (!stat.rsp_busy) begin
                     cmd.finish = 1'b1;
                     cmd.status = RS_AUTO_FULL;
                     state_in   = ST_IDLE;
                  end
               end
            end
         end

         ST_MOD: begin
            cmd.table_auto = 1'b1;
            if (!stat.mod_busy && !stat.rsp_busy) begin
               cmd.finish       = 1'b1;
               cmd.status       = RS_NEW;
               cmd.grp_sel      = GRP_NEW;
               cmd.auto_write   = 1'b1;
               cmd.count_update = 1'b1;
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/dwat_dp.sv
// Datapath of the affinity table: request registers, tables, scan compare, modulo unit, result.
module dwat_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [dwat_pkg::POOL_W-1:0]    csr_pool_size,
   input  logic [1:0]                     req_operation,
   input  logic                           req_has_device,
   input  logic [31:0]                    req_device_key,
   input  logic [dwat_pkg::GROUP_W-1:0]   req_pin_thread,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_status,
   output logic [dwat_pkg::GROUP_W-1:0]   rsp_group_number,
   input  dwat_pkg::cmd_type              cmd,
   output dwat_pkg::stat_type             stat
);
   import dwat_pkg::*;

   localparam logic [SCAN_W-1:0] USER_LAST = SCAN_W'(USER_DEPTH - 1);
   localparam logic [SCAN_W-1:0] AUTO_LAST = SCAN_W'(AUTO_DEPTH - 1);

   // Request word and configuration.
   logic [1:0]          op_ff;
   logic                has_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [GROUP_W-1:0]  pin_ff;
   logic [POOL_W-1:0]   pool_ff;
   logic [COUNT_W-1:0]  count_ff;

   // Tables: entry storage in memories, valid bits in flops.
   logic [ENTRY_W-1:0]    user_mem [USER_DEPTH];
   logic [ENTRY_W-1:0]    auto_mem [AUTO_DEPTH];
   logic [ENTRY_W-1:0]    user_rd_ff;
   logic [ENTRY_W-1:0]    auto_rd_ff;
   logic [USER_DEPTH-1:0] user_valid_ff;
   logic [AUTO_DEPTH-1:0] auto_valid_ff;

   // Scan state.
   logic [SCAN_W-1:0]  addr_ff;
   logic               issue_done_ff;
   logic               cmp_vld_ff;
   logic [SCAN_W-1:0]  cmp_idx_ff;
   logic               cmp_last_ff;
   logic               done_ff;
   logic               hit_ff;
   logic [SCAN_W-1:0]  hit_idx_ff;
   logic [GROUP_W-1:0] hit_grp_ff;
   logic               free_found_ff;
   logic [SCAN_W-1:0]  free_idx_ff;

   // Modulo unit.
   logic [POOL_W-1:0]    rem_ff;
   logic [MOD_IDX_W-1:0] mod_idx_ff;
   logic                 mod_busy_ff;

   logic                 rsp_valid_ff;
   logic [2:0]           rsp_status_ff;
   logic [GROUP_W-1:0]   rsp_group_ff;

   logic [SCAN_W-1:0]  last_idx;
   logic [ENTRY_W-1:0] cmp_entry;
   logic               cmp_vbit;
   logic               cmp_match;
   logic [COUNT_W-1:0] count_in;
   logic [POOL_W:0]    rem_shift;
   logic [POOL_W:0]    rem_sub;
   logic [GROUP_W-1:0] new_group;
   logic [GROUP_W-1:0] group_sel;
   logic [SCAN_W-1:0]  user_wr_idx;

   assign last_idx  = cmd.table_auto ? AUTO_LAST : USER_LAST;
   assign cmp_entry = cmd.table_auto ? auto_rd_ff : user_rd_ff;
   assign cmp_vbit  = cmd.table_auto ? auto_valid_ff[cmp_idx_ff[AIDX_W-1:0]]
                                     : user_valid_ff[cmp_idx_ff[UIDX_W-1:0]];
   assign cmp_match = cmp_vbit && (cmp_entry[ENTRY_W-1:GROUP_W] == key_ff);

   assign count_in  = count_ff + COUNT_W'(1);
   assign rem_shift = {rem_ff, count_in[mod_idx_ff]};
   assign rem_sub   = rem_shift - {1'b0, pool_ff};
   assign new_group = ({1'b0, count_in} <= (COUNT_W + 1)'(pool_ff)) ?
                      GROUP_W'(count_in) : GROUP_W'(rem_ff + POOL_W'(1));
   assign user_wr_idx = hit_ff ? hit_idx_ff : free_idx_ff;

   always_comb begin
      case (cmd.grp_sel)
         GRP_PIN: group_sel = pin_ff;
         GRP_HIT: group_sel = hit_grp_ff;
         GRP_NEW: group_sel = new_group;
         default: group_sel = '0;
      endcase
   end

   // Request capture and configuration register.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_operation;
         has_ff <= req_has_device;
         key_ff <= req_device_key[KEY_W-1:0];
         pin_ff <= req_pin_thread;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (csr_valid) begin
            pool_ff <= csr_pool_size;
         end
         if (cmd.count_update) begin
            count_ff <= count_in;
         end
      end
   end

   // Memories: one registered read port and one write port each.
   always_ff @(posedge clock) begin
      user_rd_ff <= user_mem[addr_ff[UIDX_W-1:0]];
      if (cmd.user_write) begin
         user_mem[user_wr_idx[UIDX_W-1:0]] <= {key_ff, pin_ff};
      end
   end

   always_ff @(posedge clock) begin
      auto_rd_ff <= auto_mem[addr_ff[AIDX_W-1:0]];
      if (cmd.auto_write) begin
         auto_mem[free_idx_ff[AIDX_W-1:0]] <= {key_ff, new_group};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         user_valid_ff <= '0;
         auto_valid_ff <= '0;
      end else begin
         if (cmd.user_write) begin
            user_valid_ff[user_wr_idx[UIDX_W-1:0]] <= 1'b1;
         end
         if (cmd.auto_write) begin
            auto_valid_ff[free_idx_ff[AIDX_W-1:0]] <= 1'b1;
         end
      end
   end

   // Scan: one address issued per cycle, compared in the cycle after its issue.
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         issue_done_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         done_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.load || cmd.scan_clear) begin
         addr_ff       <= '0;
         issue_done_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         done_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (cmd.scan_en && !issue_done_ff) begin
            cmp_vld_ff  <= 1'b1;
            cmp_idx_ff  <= addr_ff;
            cmp_last_ff <= (addr_ff == last_idx);
            if (addr_ff == last_idx) begin
               issue_done_ff <= 1'b1;
            end else begin
               addr_ff <= addr_ff + SCAN_W'(1);
            end
         end else begin
            cmp_vld_ff <= 1'b0;
         end

         if (cmp_vld_ff && !done_ff) begin
            if (cmp_match) begin
               done_ff    <= 1'b1;
               hit_ff     <= 1'b1;
               hit_idx_ff <= cmp_idx_ff;
               hit_grp_ff <= cmp_entry[GROUP_W-1:0];
            end else begin
               if (!cmp_vbit && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_idx_ff   <= cmp_idx_ff;
               end
               if (cmp_last_ff) begin
                  done_ff <= 1'b1;
               end
            end
         end
      end
   end

   // Restoring remainder of the next counter value by the pool size, one bit a cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_busy_ff <= 1'b0;
      end else if (cmd.mod_start) begin
         mod_busy_ff <= 1'b1;
         mod_idx_ff  <= MOD_IDX_W'(COUNT_W - 1);
         rem_ff      <= '0;
      end else if (mod_busy_ff) begin
         if (!rem_sub[POOL_W]) begin
            rem_ff <= rem_sub[POOL_W-1:0];
         end else begin
            rem_ff <= rem_shift[POOL_W-1:0];
         end
         if (mod_idx_ff == '0) begin
            mod_busy_ff <= 1'b0;
         end else begin
            mod_idx_ff <= mod_idx_ff - MOD_IDX_W'(1);
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= cmd.status;
         rsp_group_ff  <= group_sel;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_group_number = rsp_group_ff;

   assign stat.op         = op_ff;
   assign stat.has_device = has_ff;
   assign stat.pool_zero  = (pool_ff == '0);
   assign stat.scan_done  = done_ff;
   assign stat.hit        = hit_ff;
   assign stat.free_found = free_found_ff;
   assign stat.mod_busy   = mod_busy_ff;
   assign stat.rsp_busy   = rsp_valid_ff && rsp_stall;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the device-to-worker affinity table core.
`timescale 1ns / 1ps

module testbench;
   import dwat_pkg::*;

   localparam int KEY_SET_N = 96;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 100;

   // One request word as it is put on the req_ channel.
   typedef struct {
      logic [1:0]         op;
      logic               has;
      logic [31:0]        key;
      logic [GROUP_W-1:0] pin;
   } affinity_req_type;

   // One response word as the block should deliver it.
   typedef struct {
      rsp_status_type     status;
      logic [GROUP_W-1:0] group;
   } affinity_answer_type;

   logic clock;
   logic reset = 1'b1;

   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [POOL_W-1:0]   csr_pool_size = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_operation = OP_ASSIGN;
   logic                req_has_device = 1'b0;
   logic [31:0]         req_device_key = '0;
   logic [GROUP_W-1:0]  req_pin_thread = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [2:0]          rsp_status;
   logic [GROUP_W-1:0]  rsp_group_number;

   device_to_worker_affinity_table_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_pool_size    (csr_pool_size),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_has_device   (req_has_device),
      .req_device_key   (req_device_key),
      .req_pin_thread   (req_pin_thread),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_group_number (rsp_group_number)
   );

   // Words waiting to be offered, and the answers the block still owes us.
   affinity_req_type    queued_requests[$];
   affinity_answer_type due_answers[$];
   int requests_queued = 0;
   int requests_taken = 0;
   int pool_writes = 0;
   int error_count = 0;

   // Percentage of cycles in which each side idles; the stimulus changes it per phase.
   int idle_pct = 20;

   // Set at a rising edge when the word on req_ was taken, so the driver knows
   // at the following falling edge that it may move on.
   logic req_taken = 1'b0;

   // Our own picture of the block: pinned (user) table, learned (auto) table,
   // the new-device counter and the pool size register.
   logic [KEY_W-1:0]   pinned_key[USER_DEPTH];
   logic [GROUP_W-1:0] pinned_group[USER_DEPTH];
   logic               pinned_used[USER_DEPTH];
   logic [KEY_W-1:0]   learned_key[AUTO_DEPTH];
   logic [GROUP_W-1:0] learned_group[AUTO_DEPTH];
   logic               learned_used[AUTO_DEPTH];
   logic [COUNT_W-1:0] new_devices = '0;
   logic [POOL_W-1:0]  pool_limit = '0;

   logic [31:0] key_set[KEY_SET_N];

   // Works out the answer to one request and updates the tables as the block
   // should. A user entry always wins over a learned one; assign with a pool size
   // of zero passes through, whatever the tables hold.
   function automatic void resolve_group(input logic [1:0] op, input logic has,
         input logic [31:0] key, input logic [GROUP_W-1:0] pin,
         output rsp_status_type status, output logic [GROUP_W-1:0] group);
      logic [KEY_W-1:0] k;
      int u;
      int a;
      int c;
      k = key[KEY_W-1:0];
      status = RS_PASS;
      group = '0;
      u = -1;
      a = -1;
      if (!has || op == OP_UNUSED) return;
      for (int i = 0; i < USER_DEPTH; i++)
         if (u < 0 && pinned_used[i] && pinned_key[i] == k) u = i;
      if (op == OP_PIN) begin
         // A key already pinned is overwritten in place; otherwise take the first free slot.
         for (int i = 0; i < USER_DEPTH; i++)
            if (u < 0 && !pinned_used[i]) u = i;
         if (u < 0) begin
            status = RS_USER_FULL;
         end else begin
            pinned_key[u] = k;
            pinned_group[u] = pin;
            pinned_used[u] = 1'b1;
            status = RS_PINNED;
            group = pin;
         end
      end else if (op == OP_ASSIGN && pool_limit == 0) begin
         status = RS_PASS;
      end else if (u >= 0) begin
         status = RS_USER_HIT;
         group = pinned_group[u];
      end else begin
         for (int i = 0; i < AUTO_DEPTH; i++)
            if (a < 0 && learned_used[i] && learned_key[i] == k) a = i;
         if (a >= 0) begin
            status = RS_AUTO_HIT;
            group = learned_group[a];
         end else if (op == OP_QUERY) begin
            status = RS_NOT_MAPPED;
         end else begin
            for (int i = 0; i < AUTO_DEPTH; i++)
               if (a < 0 && !learned_used[i]) a = i;
            if (a < 0) begin
               // Learned table full: nothing stored and the counter stays put.
               status = RS_AUTO_FULL;
            end else begin
               c = (int'(new_devices) + 1) % (1 << COUNT_W);
               new_devices = COUNT_W'(c);
               if (c <= int'(pool_limit))
                  group = GROUP_W'(c);
               else
                  group = GROUP_W'((c % int'(pool_limit)) + 1);
               learned_key[a] = k;
               learned_group[a] = group;
               learned_used[a] = 1'b1;
               status = RS_NEW;
            end
         end
      end
   endfunction

   // A random request. Most keys come from a fixed set so that pins, hits and
   // full tables all show up; the rest are fresh keys.
   function automatic affinity_req_type random_req();
      affinity_req_type r;
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 50)
         r.op = OP_ASSIGN;
      else if (sel < 78)
         r.op = OP_QUERY;
      else if (sel < 95)
         r.op = OP_PIN;
      else
         r.op = OP_UNUSED;
      r.has = ($urandom_range(0, 99) >= 5);
      if ($urandom_range(0, 99) < 85)
         r.key = key_set[$urandom_range(0, KEY_SET_N - 1)];
      else
         r.key = $urandom;
      r.pin = GROUP_W'($urandom_range(0, 255));
      return r;
   endfunction

   task automatic queue_req(input logic [1:0] op, input logic has, input logic [31:0] key,
         input logic [GROUP_W-1:0] pin);
      affinity_req_type r;
      r.op = op;
      r.has = has;
      r.key = key;
      r.pin = pin;
      queued_requests.insert(queued_requests.size(), r);
      requests_queued++;
   endtask

   // Returns at a falling edge once every queued word has been taken and answered.
   // Each request gives exactly one answer, so the block is idle at that point.
   task automatic wait_idle();
      do
         @(negedge clock);
      while (requests_taken != requests_queued || due_answers.size() != 0);
   endtask

   task automatic write_pool(input logic [POOL_W-1:0] value);
      int target;
      wait_idle();
      target = pool_writes + 1;
      csr_valid = 1'b1;
      csr_pool_size = value;
      do
         @(negedge clock);
      while (pool_writes != target);
      csr_valid = 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Driver: a word stays on req_ until it is taken, then the next one (or a gap)
   // follows at the falling edge.
   always @(negedge clock) begin
      affinity_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (queued_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            nxt = queued_requests.pop_front();
            req_valid <= 1'b1;
            req_operation <= nxt.op;
            req_has_device <= nxt.has;
            req_device_key <= nxt.key;
            req_pin_thread <= nxt.pin;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off while plenty of words are
   // still waiting, so the output register fills and the block stalls its input.
   int  hold_left = 0;
   bit  long_hold_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!long_hold_done && requests_taken >= 300 && queued_requests.size() > 20) begin
            hold_left = HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < idle_pct);
         end
      end
   end

   // Monitor: checks each delivered word against the oldest answer due, tracks
   // register writes, and predicts the answer for each word taken on req_.
   // The check comes first, so a word taken at this edge can never be matched
   // against a response delivered at the same edge.
   always @(posedge clock) begin
      affinity_answer_type ans;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (due_answers.size() == 0) begin
               $error("response with nothing outstanding: status %0d group %0d",
                      rsp_status, rsp_group_number);
               error_count++;
            end else begin
               ans = due_answers.pop_front();
               if (rsp_status !== ans.status) begin
                  $error("status: expected %0d, got %0d", ans.status, rsp_status);
                  error_count++;
               end
               if (rsp_group_number !== ans.group) begin
                  $error("group_number: expected %0d, got %0d", ans.group, rsp_group_number);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready === 1'b1) begin
            pool_limit = csr_pool_size;
            pool_writes++;
         end
         req_taken <= req_valid && req_stall === 1'b0;
         if (req_valid && req_stall === 1'b0) begin
            resolve_group(req_operation, req_has_device, req_device_key, req_pin_thread,
                          ans.status, ans.group);
            due_answers.insert(due_answers.size(), ans);
            requests_taken++;
         end
      end
   end

   // Stimulus: reset, a short directed part across three pool sizes, then random
   // phases, each under its own pool size.
   initial begin
      logic [POOL_W-1:0] phase_pool[7];
      phase_pool = '{8'd5, 8'd40, 8'd255, 8'd0, 8'd1, 8'd128, 8'd3};
      for (int i = 0; i < USER_DEPTH; i++) pinned_used[i] = 1'b0;
      for (int i = 0; i < AUTO_DEPTH; i++) learned_used[i] = 1'b0;
      for (int i = 0; i < KEY_SET_N; i++) key_set[i] = $urandom;
      key_set[0] = 32'h0000_0000;
      key_set[1] = 32'hFFFF_FFFF;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Pool size is zero out of reset: assign passes through, pin and query
      // still work, and words without a key or with the unused code pass through.
      queue_req(OP_ASSIGN, 1'b1, 32'h0000_1234, 8'd0);
      queue_req(OP_QUERY,  1'b0, 32'h0000_1234, 8'd0);
      queue_req(OP_PIN,    1'b0, 32'h0000_1234, 8'd9);
      queue_req(OP_ASSIGN, 1'b0, 32'h0000_1234, 8'd0);
      queue_req(OP_UNUSED, 1'b1, 32'h0000_1234, 8'd3);
      queue_req(OP_PIN,    1'b1, 32'h0000_0000, 8'd0);
      queue_req(OP_PIN,    1'b1, 32'hFFFF_FFFF, 8'd255);
      queue_req(OP_QUERY,  1'b1, 32'h0000_0000, 8'd0);
      queue_req(OP_QUERY,  1'b1, 32'hFFFF_FFFF, 8'd0);
      queue_req(OP_QUERY,  1'b1, 32'hA5A5_A5A5, 8'd0);
      queue_req(OP_ASSIGN, 1'b1, 32'h0000_0000, 8'd0);

      // Pool of one: a new device, the same device again, a user entry winning,
      // a pin over a learned entry, a re-pin, and the wrap of the counter past
      // the pool size.
      write_pool(8'd1);
      queue_req(OP_ASSIGN, 1'b1, 32'hA5A5_A5A5, 8'd0);
      queue_req(OP_ASSIGN, 1'b1, 32'hA5A5_A5A5, 8'd0);
      queue_req(OP_ASSIGN, 1'b1, 32'hFFFF_FFFF, 8'd0);
      queue_req(OP_QUERY,  1'b1, 32'hA5A5_A5A5, 8'd0);
      queue_req(OP_PIN,    1'b1, 32'hA5A5_A5A5, 8'h5A);
      queue_req(OP_QUERY,  1'b1, 32'hA5A5_A5A5, 8'd0);
      queue_req(OP_PIN,    1'b1, 32'hFFFF_FFFF, 8'd7);
      queue_req(OP_ASSIGN, 1'b1, 32'h5A5A_5A5A, 8'd0);

      // Largest pool: the counter value is used as it is.
      write_pool(8'd255);
      queue_req(OP_ASSIGN, 1'b1, 32'h0F0F_0F0F, 8'd0);
      queue_req(OP_ASSIGN, 1'b1, 32'hF0F0_F0F0, 8'd0);
      queue_req(OP_QUERY,  1'b1, 32'h1234_5678, 8'd0);

      // Random phases. Fresh devices soon fill the learned table and pins fill the
      // user table, so the full cases come up as the run goes on.
      foreach (phase_pool[p]) begin
         affinity_req_type r;
         write_pool(phase_pool[p]);
         idle_pct = (p == 2) ? 0 : 20;
         repeat (100) begin
            r = random_req();
            queue_req(r.op, r.has, r.key, r.pin);
         end
      end
      idle_pct = 20;

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #(5_000_000);
      $display("FAIL");
      $finish;
   end

endmodule
